[rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `ASSERT_ALWAYS(lbl, clk, rst_n, !(expr))

`endif

[rtl/mrc_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// mrc_pkg: shared types and constants for the Modbus RTU CRC unit
// CRC-16/MODBUS byte table, command codes between front and back end,
// and result kind codes.
// ---------------------------------------------------------------------------
package mrc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int MRC_FIFO_DEPTH = 4;

    // command codes, front to back
    localparam logic [1:0] OP_DATA      = 2'd0;
    localparam logic [1:0] OP_DATA_LAST = 2'd1;
    localparam logic [1:0] OP_VERDICT   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_CRC     = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data;
        logic [15:0] crc;
        logic        ok;
    } t_mrc_cmd;

    // one entry of the reflected byte table
    function automatic logic [15:0] f_crc_table(input logic [7:0] idx);
        logic [15:0] c;
        c = {8'h00, idx};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] f_crc_feed(input logic [15:0] crc,
                                               input logic [7:0]  b);
        return {8'h00, crc[15:8]} ^ f_crc_table(crc[7:0] ^ b);
    endfunction

endpackage
`default_nettype wire

[rtl/modbus_rtu_crc_append_check.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// modbus_rtu_crc_append_check: Modbus RTU CRC-16 append and check unit
// Use: write frame_mode through i_cfg_we / i_frame_mode while idle (0 append,
// 1 check); each write restarts the frame in progress.
// Input requests: byte plus frame-end mark, taken on push while full is low.
// Results: read from the queue-style port; the oldest result sits on the
// o_ ports while empty is low and is taken on pop.
// Generate mode: every byte is passed on; after the last byte of a frame the
// CRC follows, low byte first, the high byte marked last.
// Check mode: no output until frame end, then one verdict item.
// Path: a request is queued at the edge that takes it and is loaded into the
// output register once that register is free and no CRC bytes are pending.
// Throughput: one byte per cycle while full is low, set by the combinational
// CRC table update in the front end; the frame-end CRC bytes are two extra output items.
// Stall: a held pop freezes the output register; the command queue
// (FIFO_DEPTH entries) then fills and full rises to hold off the sender.
// Reset: synchronous, active low; CRC to 0xFFFF, mode to generate, queue
// and output emptied.
// ---------------------------------------------------------------------------
module modbus_rtu_crc_append_check #(
    parameter int FIFO_DEPTH = mrc_pkg::MRC_FIFO_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration
    input  wire logic       i_cfg_we,
    input  wire logic       i_frame_mode,
    // request side
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_frame_end,
    // result side
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_out_kind,
    output logic            o_out_last,
    output logic            o_frame_ok
);
    import mrc_pkg::*;

    t_mrc_cmd wr_cmd;
    t_mrc_cmd rd_cmd;
    logic     cmd_push;
    logic     cmd_pop;
    logic     q_empty;

    // front end: track the CRC and issue one command per result group
    mrc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_frame_mode (i_frame_mode),
        .i_push       (push),
        .i_data_byte  (i_data_byte),
        .i_frame_end  (i_frame_end),
        .i_q_full     (full),
        .o_cmd        (wr_cmd),
        .o_cmd_push   (cmd_push)
    );

    // decouple intake from the result port
    mrc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (cmd_push),
        .i_wr_data (wr_cmd),
        .i_pop     (cmd_pop),
        .o_rd_data (rd_cmd),
        .o_full    (full),
        .o_empty   (q_empty)
    );

    // back end: expand commands into result items
    mrc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (rd_cmd),
        .i_q_empty  (q_empty),
        .o_q_pop    (cmd_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_out_kind (o_out_kind),
        .o_out_last (o_out_last),
        .o_frame_ok (o_frame_ok)
    );

endmodule
`default_nettype wire

[rtl/mrc_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// mrc_front: request intake and CRC tracking
// Accepts frame bytes, updates the running CRC and the check-mode hold-back
// bytes, and issues one command per result group to the back end.
// ---------------------------------------------------------------------------
module mrc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_frame_mode,
    input  wire logic            i_push,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_frame_end,
    input  wire logic            i_q_full,
    output mrc_pkg::t_mrc_cmd    o_cmd,
    output logic                 o_cmd_push
);
    import mrc_pkg::*;

    logic        r_mode;
    logic [15:0] r_crc,  n_crc;
    logic [15:0] r_held, n_held;
    logic [1:0]  r_cnt,  n_cnt;

    logic        accept;
    logic [15:0] crc_gen;
    logic [15:0] crc_chk;

    assign accept  = i_push && !i_q_full;
    assign crc_gen = f_crc_feed(r_crc, i_data_byte);
    assign crc_chk = (r_cnt == 2'd2) ? f_crc_feed(r_crc, r_held[15:8]) : r_crc;

    always_comb begin
        n_crc      = r_crc;
        n_held     = r_held;
        n_cnt      = r_cnt;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        if (accept) begin
            if (!r_mode) begin
                o_cmd_push = 1'b1;
                o_cmd.op   = i_frame_end ? OP_DATA_LAST : OP_DATA;
                o_cmd.data = i_data_byte;
                o_cmd.crc  = crc_gen;
                n_crc      = i_frame_end ? CRC_INIT : crc_gen;
            end else begin
                n_held = {r_held[7:0], i_data_byte};
                n_cnt  = (r_cnt == 2'd2) ? 2'd2 : r_cnt + 2'd1;
                n_crc  = crc_chk;
                if (i_frame_end) begin
                    o_cmd_push = 1'b1;
                    o_cmd.op   = OP_VERDICT;
                    o_cmd.ok   = (r_cnt != 2'd0) && (r_held[7:0] == crc_chk[7:0])
                                 && (i_data_byte == crc_chk[15:8]);
                    n_crc      = CRC_INIT;
                    n_held     = '0;
                    n_cnt      = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_crc  <= CRC_INIT;
            r_held <= '0;
            r_cnt  <= '0;
        end else if (i_cfg_we) begin
            // mode write restarts the frame
            r_mode <= i_frame_mode;
            r_crc  <= CRC_INIT;
            r_held <= '0;
            r_cnt  <= '0;
        end else begin
            r_crc  <= n_crc;
            r_held <= n_held;
            r_cnt  <= n_cnt;
        end
    end

endmodule
`default_nettype wire

[rtl/mrc_fifo.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// mrc_fifo: command queue between front and back end
// Small first-in first-out store of commands with full and empty flags.
// ---------------------------------------------------------------------------
module mrc_fifo #(
    parameter int DEPTH = mrc_pkg::MRC_FIFO_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire mrc_pkg::t_mrc_cmd  i_wr_data,
    input  wire logic               i_pop,
    output mrc_pkg::t_mrc_cmd       o_rd_data,
    output logic                    o_full,
    output logic                    o_empty
);
    import mrc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_mrc_cmd      r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

[rtl/mrc_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// mrc_back: result sequencer
// Expands queued commands into result items and holds the oldest one in
// the output register until it is popped.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module mrc_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mrc_pkg::t_mrc_cmd  i_cmd,
    input  wire logic               i_q_empty,
    output logic                    o_q_pop,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output logic [7:0]              o_out_byte,
    output logic [1:0]              o_out_kind,
    output logic                    o_out_last,
    output logic                    o_frame_ok
);
    import mrc_pkg::*;

    localparam logic [1:0] STEP_IDLE = 2'd0;
    localparam logic [1:0] STEP_LO   = 2'd1;
    localparam logic [1:0] STEP_HI   = 2'd2;

    logic        r_vld;
    logic [1:0]  r_step;
    logic [15:0] r_crc;
    logic [7:0]  r_byte;
    logic [1:0]  r_kind;
    logic        r_last;
    logic        r_ok;

    logic load;

    assign load    = !r_vld || i_pop;
    assign o_q_pop = load && (r_step == STEP_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_step <= STEP_IDLE;
        end else if (load) begin
            priority if (r_step == STEP_LO) begin
                r_vld  <= 1'b1;
                r_step <= STEP_HI;
            end else if (r_step == STEP_HI) begin
                r_vld  <= 1'b1;
                r_step <= STEP_IDLE;
            end else if (!i_q_empty) begin
                r_vld  <= 1'b1;
                r_step <= (i_cmd.op == OP_DATA_LAST) ? STEP_LO : STEP_IDLE;
            end else begin
                r_vld  <= 1'b0;
            end
        end
    end

    // payload of the output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            priority if (r_step == STEP_LO) begin
                r_byte <= r_crc[7:0];
                r_kind <= KIND_CRC;
                r_last <= 1'b0;
                r_ok   <= 1'b0;
            end else if (r_step == STEP_HI) begin
                r_byte <= r_crc[15:8];
                r_kind <= KIND_CRC;
                r_last <= 1'b1;
                r_ok   <= 1'b0;
            end else if (!i_q_empty) begin
                r_crc <= i_cmd.crc;
                unique case (i_cmd.op)
                    OP_VERDICT: begin
                        r_byte <= '0;
                        r_kind <= KIND_VERDICT;
                        r_last <= 1'b1;
                        r_ok   <= i_cmd.ok;
                    end
                    default: begin
                        r_byte <= i_cmd.data;
                        r_kind <= KIND_DATA;
                        r_last <= 1'b0;
                        r_ok   <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_empty    = !r_vld;
    assign o_out_byte = r_byte;
    assign o_out_kind = r_kind;
    assign o_out_last = r_last;
    assign o_frame_ok = r_ok;

    `ASSERT_NEVER(a_pop_on_empty, i_clk, i_rst_n, o_q_pop && i_q_empty)
    `ASSERT_ALWAYS(a_step_has_output, i_clk, i_rst_n, (r_step != STEP_IDLE) |-> r_vld)
    `ASSERT_ALWAYS(a_crc_lo_then_hi, i_clk, i_rst_n, (r_vld && r_kind == KIND_CRC && !r_last) |-> (r_step == STEP_HI))
    `ASSERT_ALWAYS(a_verdict_shape, i_clk, i_rst_n, (r_vld && r_kind == KIND_VERDICT) |-> (r_last && r_byte == 8'h00))

endmodule
`default_nettype wire

[bench/modbus_rtu_crc_append_check_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// modbus_rtu_crc_append_check_tb: self-checking bench for the Modbus CRC unit
// Sends frame bytes through the push/full port and tracks CRC-16/MODBUS on
// the bench side for both frame modes. Every result popped from the unit is
// compared field by field with the oldest outstanding prediction. Both sides
// stall at random, and one long receiver hold-off fills the unit.
// ---------------------------------------------------------------------------
module modbus_rtu_crc_append_check_tb;

    import mrc_pkg::*;

    localparam int          CLK_PERIOD     = 20;
    localparam int          RESET_CYCLES   = 11;
    // pipeline margin, plus margin for trailing check-mode bytes
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          PHASE_ITEMS    = 65;
    localparam int          PRESSURE_ITEMS = 40;
    localparam int          TIMEOUT_CYCLES = 200_000;

    localparam logic        MODE_GENERATE  = 1'b0;
    localparam logic        MODE_CHECK     = 1'b1;

    typedef struct {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       out_last;
        logic       frame_ok;
    } t_crc_result;

    // DUT connections, all inputs known from time zero
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_cfg_we     = 1'b0;
    logic       i_frame_mode = 1'b0;
    logic       push         = 1'b0;
    logic       full;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_frame_end  = 1'b0;
    logic       empty;
    logic       pop          = 1'b0;
    logic [7:0] o_out_byte;
    logic [1:0] o_out_kind;
    logic       o_out_last;
    logic       o_frame_ok;

    // bench control, changed by nonblocking assignment only
    logic       idle_enable  = 1'b1;
    logic       hold_off     = 1'b0;

    // shadow of the unit: running CRC, held pair, mode
    logic [15:0] shadow_crc;
    logic [15:0] shadow_held;
    logic [1:0]  shadow_held_num;
    logic        shadow_mode;

    t_crc_result due_results[$];
    logic [7:0]  frame_buf[$];
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;

    modbus_rtu_crc_append_check dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_frame_mode (i_frame_mode),
        .push         (push),
        .full         (full),
        .i_data_byte  (i_data_byte),
        .i_frame_end  (i_frame_end),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_out_kind   (o_out_kind),
        .o_out_last   (o_out_last),
        .o_frame_ok   (o_frame_ok)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // CRC arithmetic and prediction
    // -----------------------------------------------------------------------

    // one byte into a reflected CRC-16, bit by bit
    function automatic logic [15:0] crc16_absorb(input logic [15:0] crc,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void shadow_restart();
        shadow_crc      = CRC_INIT;
        shadow_held     = 16'h0000;
        shadow_held_num = 2'd0;
    endfunction

    function automatic void queue_result(input logic [7:0] b, input logic [1:0] kind,
                                         input logic last, input logic ok);
        t_crc_result r;
        r.out_byte = b;
        r.out_kind = kind;
        r.out_last = last;
        r.frame_ok = ok;
        due_results.push_back(r);
    endfunction

    // Work out what one accepted request produces and advance the shadow.
    function automatic void forecast_byte(input logic [7:0] b, input logic last);
        logic ok;
        if (shadow_mode == MODE_GENERATE) begin
            shadow_crc = crc16_absorb(shadow_crc, b);
            queue_result(b, KIND_DATA, 1'b0, 1'b0);
            if (last) begin
                // CRC goes out low byte first, high byte closes the frame
                queue_result(shadow_crc[7:0], KIND_CRC, 1'b0, 1'b0);
                queue_result(shadow_crc[15:8], KIND_CRC, 1'b1, 1'b0);
                shadow_restart();
            end
        end else begin
            // only bytes older than the newest two enter the CRC
            if (shadow_held_num >= 2'd2) begin
                shadow_crc = crc16_absorb(shadow_crc, shadow_held[15:8]);
            end
            shadow_held = {shadow_held[7:0], b};
            if (shadow_held_num < 2'd2) begin
                shadow_held_num = shadow_held_num + 2'd1;
            end
            if (last) begin
                // a frame of fewer than two bytes can never pass
                ok = (shadow_held_num >= 2'd2)
                     && (shadow_held[15:8] == shadow_crc[7:0])
                     && (shadow_held[7:0] == shadow_crc[15:8]);
                queue_result(8'h00, KIND_VERDICT, 1'b1, ok);
                shadow_restart();
            end
        end
    endfunction

    // -----------------------------------------------------------------------
    // Request side
    // -----------------------------------------------------------------------

    // Offer one request, with an optional random gap first; return once the
    // unit has taken it. push stays high so back-to-back requests need no
    // second assignment in the same step.
    task automatic send_item(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        i_frame_end <= last;
        do @(posedge i_clk); while (full);
        forecast_byte(b, last);
        items_sent++;
    endtask

    // Send frame_buf as one frame, last byte marked, and clear it.
    task automatic send_frame();
        for (int k = 0; k < frame_buf.size(); k++) begin
            send_item(frame_buf[k], k == frame_buf.size() - 1);
        end
        frame_buf.delete();
    endtask

    // Append the frame's CRC, low byte first; flip corrupts it on purpose.
    task automatic append_crc(input logic [15:0] flip);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_buf[k]) begin
            c = crc16_absorb(c, frame_buf[k]);
        end
        c = c ^ flip;
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endtask

    task automatic fill_random_bytes(input int unsigned n);
        repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // Drop push and wait until every predicted result has been popped, then
    // let the pipeline settle so no request is still in flight.
    task automatic wait_drained();
        push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mode writes happen only while the unit is idle; each one restarts the
    // frame in progress.
    task automatic write_frame_mode(input logic mode);
        wait_drained();
        i_cfg_we     <= 1'b1;
        i_frame_mode <= mode;
        @(posedge i_clk);
        shadow_mode = mode;
        shadow_restart();
        i_cfg_we     <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Result side: check each popped result, then decide on the next pop
    // -----------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    initial begin : result_monitor
        int unsigned stall_left;
        t_crc_result want;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (due_results.size() == 0) begin
                    $error("result with none due: byte %0h kind %0d last %0b ok %0b",
                           o_out_byte, o_out_kind, o_out_last, o_frame_ok);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("out_byte", want.out_byte, o_out_byte);
                    check_field("out_kind", {6'd0, want.out_kind}, {6'd0, o_out_kind});
                    check_field("out_last", {7'd0, want.out_last}, {7'd0, o_out_last});
                    check_field("frame_ok", {7'd0, want.frame_ok}, {7'd0, o_frame_ok});
                end
            end
            // hold pop low through a long hold-off or a random stall burst
            if (hold_off) begin
                pop <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Generate mode from reset: single-byte frames at both byte extremes and
    // a classic read-holding-registers request.
    task automatic test_generate_directed();
        frame_buf = '{8'h00};
        send_frame();
        frame_buf = '{8'hFF};
        send_frame();
        frame_buf = '{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h0A};
        send_frame();
    endtask

    // Check mode: good frame, one-byte frame, two-byte frame that equals the
    // CRC of nothing, and a frame with a wrong CRC.
    task automatic test_check_directed();
        write_frame_mode(MODE_CHECK);
        frame_buf = '{8'h11, 8'h03};
        append_crc(16'h0000);
        send_frame();
        // too short to carry a CRC
        frame_buf = '{8'h5A};
        send_frame();
        // empty payload: the CRC bytes alone, FF FF
        append_crc(16'h0000);
        send_frame();
        frame_buf = '{8'hA5};
        append_crc(16'h0001);
        send_frame();
    endtask

    // A mode write in the middle of a frame throws away what was gathered,
    // even when the new mode equals the old one.
    task automatic test_mode_restart();
        send_item(8'h80, 1'b0);
        send_item(8'h7F, 1'b0);
        write_frame_mode(MODE_CHECK);
        frame_buf = '{8'h42};
        append_crc(16'h0000);
        send_frame();
        write_frame_mode(MODE_GENERATE);
        send_item(8'hC3, 1'b0);
        send_item(8'h3C, 1'b0);
        write_frame_mode(MODE_GENERATE);
        send_item(8'h01, 1'b1);
    endtask

    // Hold the receiver off for a long stretch while requests keep coming,
    // so the command queue fills and full pushes back on the sender.
    task automatic test_backpressure();
        int unsigned sent_at_start;
        sent_at_start = items_sent;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            begin
                while (items_sent - sent_at_start < PRESSURE_ITEMS) begin
                    fill_random_bytes($urandom_range(1, 8));
                    send_frame();
                end
            end
        join
    endtask

    // One random phase in the given mode. Check mode is mostly well-formed
    // frames with random content, the rest corrupted or plain noise.
    task automatic test_random_frames(input logic mode);
        int unsigned sent_at_start;
        int unsigned pick;
        int unsigned idx;
        sent_at_start = items_sent;
        write_frame_mode(mode);
        while (items_sent - sent_at_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (mode == MODE_GENERATE) begin
                fill_random_bytes(pick == 0 ? $urandom_range(9, 24) : $urandom_range(1, 8));
            end else if (pick < 17) begin
                fill_random_bytes(pick == 0 ? $urandom_range(7, 16) : $urandom_range(0, 6));
                append_crc(16'h0000);
                if (pick >= 14) begin
                    // damage one byte of an otherwise good frame
                    idx = $urandom_range(0, frame_buf.size() - 1);
                    frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
                end
            end else begin
                fill_random_bytes($urandom_range(1, 4));
            end
            send_frame();
        end
        // leave a frame unfinished now and then; the next mode write drops it
        repeat ($urandom_range(0, 2)) send_item(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------

    initial begin : main_sequence
        shadow_mode = MODE_GENERATE;
        shadow_restart();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_generate_directed();
        test_check_directed();
        test_mode_restart();
        test_backpressure();
        test_random_frames(MODE_CHECK);
        test_random_frames(MODE_GENERATE);
        test_random_frames(MODE_CHECK);
        test_random_frames(MODE_GENERATE);
        test_random_frames(MODE_CHECK);
        // last phase runs flat out on both sides
        idle_enable <= 1'b0;
        test_random_frames(MODE_GENERATE);

        wait_drained();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
